@@ rtl/mss_pkg.sv @@
// Shared constants and types for the sorted-chain median core.
package mss_pkg;

   localparam int MAX_ITEMS     = 64;
   localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
   localparam int SAMPLE_W      = 16;
   localparam int MEDIAN_W      = SAMPLE_W + 1;
   localparam int ITEM_COUNT_W  = 7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MEDIAN_W-1:0] median_type;
   typedef logic [CNT_W-1:0]           count_type;
   typedef logic [ITEM_COUNT_W-1:0]    item_count_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;   // place the broadcast sample into sorted position
      logic drain;    // move every value one cell toward cell 0
   } cell_ctrl_type;

endpackage

@@ rtl/mss_req_if.sv @@
// Input item channel: one sample per item, last sample of a set marked.
interface mss_req_if;
   import mss_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_value;
   logic       last_item;

   modport source (output valid, output sample_value, output last_item, input ready);
   modport sink   (input valid, input sample_value, input last_item, output ready);
endinterface

@@ rtl/mss_rsp_if.sv @@
// Result item channel: median times two, kept count and overflow flag.
interface mss_rsp_if;
   import mss_pkg::*;

   logic           valid;
   logic           ready;
   median_type     median_twice;
   item_count_type item_count;
   logic           overflowed;

   modport source (output valid, output median_twice, output item_count,
                   output overflowed, input ready);
   modport sink   (input valid, input median_twice, input item_count,
                   input overflowed, output ready);
endinterface

@@ rtl/mss_cell.sv @@
// One compare-and-shift cell of the sorted chain.
module mss_cell (
   input  logic                   clock,
   input  mss_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  mss_pkg::sample_type    new_sample,
   input  logic                   shift_prev,
   input  mss_pkg::sample_type    val_prev,
   input  mss_pkg::sample_type    val_next,
   output logic                   shift,
   output mss_pkg::sample_type    val
);
   import mss_pkg::*;

   sample_type val_ff;
   sample_type val_in;

   // An empty cell always yields; an occupied one yields if it holds a greater value.
   assign shift = !occupied || (val_ff > new_sample);
   assign val   = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.insert) begin
         if (shift) begin
            val_in = shift_prev ? val_prev : new_sample;
         end
      end else if (ctrl.drain) begin
         val_in = val_next;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ rtl/median_of_sample_set_core.sv @@
// Top level of the median core: sorted cell chain, drain sequencer and result register.
//
// Usage:
//   req_if carries one signed 16-bit sample per item; last_item marks the final
//   sample of a set. Each sample is inserted into a chain of MAX_ITEMS
//   compare-and-shift cells that keeps the set in ascending order, one item per
//   cycle while req_if.ready is high. A sample arriving with the chain full is
//   dropped and the set is flagged as overflowed.
//   On the last item the chain drains toward cell 0, one element per cycle,
//   until the middle element(s) have passed; the result item (median times two,
//   kept count, overflow flag) is then loaded into the output register on
//   rsp_if. Count and overflow clear for the next set.
//   req_if.ready stays low after a last item, through the drain (ST_DRAIN) and
//   until the result is loaded (ST_FINISH); non-last items leave it high, so no
//   new sample is taken until the set in the chain has been published.
//   A result that waits in the output register does not block new samples; only
//   the next set's completion waits while rsp_if.ready is low.
//   Reset (synchronous, active high) empties the set and drops any pending result.
module median_of_sample_set_core (
   input  logic      clock,
   input  logic      reset,
   mss_req_if.sink   req_if,
   mss_rsp_if.source rsp_if
);
   import mss_pkg::*;

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_DRAIN  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]     state_ff, state_in;
   count_type      count_ff, count_in;
   count_type      step_ff, step_in;
   logic           overflow_ff, overflow_in;
   sample_type     lo_ff, lo_in;
   sample_type     hi_ff, hi_in;
   logic           rsp_valid_ff, rsp_valid_in;
   median_type     rsp_median_ff, rsp_median_in;
   item_count_type rsp_count_ff, rsp_count_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   cell_ctrl_type  ctrl;
   logic           accept;
   logic           room;
   logic           rsp_free;
   count_type      half;
   count_type      lo_step;

   sample_type     cell_val   [MAX_ITEMS];
   logic           cell_shift [MAX_ITEMS];

   assign accept   = req_if.valid && req_if.ready;
   assign room     = (count_ff < count_type'(MAX_ITEMS));
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign half     = {1'b0, count_ff[CNT_W-1:1]};
   // Odd count: both captures hit the middle element; even: the lower one comes first.
   assign lo_step  = count_ff[0] ? half : (half - count_type'(1));

   assign req_if.ready = (state_ff == ST_ACCEPT);

   assign ctrl.insert = accept && room;
   assign ctrl.drain  = (state_ff == ST_DRAIN);

   // Chain of cells: cell 0 holds the smallest kept sample.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic       shift_prev;
      sample_type val_prev;
      sample_type val_next;

      if (i == 0) begin : g_head
         assign shift_prev = 1'b0;
         assign val_prev   = req_if.sample_value;
      end else begin : g_body
         assign shift_prev = cell_shift[i-1];
         assign val_prev   = cell_val[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign val_next = cell_val[i];
      end else begin : g_inner
         assign val_next = cell_val[i+1];
      end

      mss_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (count_type'(i) < count_ff),
         .new_sample (req_if.sample_value),
         .shift_prev (shift_prev),
         .val_prev   (val_prev),
         .val_next   (val_next),
         .shift      (cell_shift[i]),
         .val        (cell_val[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      overflow_in   = overflow_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      case (state_ff)
         ST_ACCEPT: begin
            if (accept) begin
               // Keep the sample if there is room, otherwise drop it and flag the set.
               if (room) begin
                  count_in = count_ff + count_type'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_if.last_item) begin
                  step_in  = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // Cell 0 holds sorted element step_ff this cycle.
            if (step_ff == lo_step) begin
               lo_in = cell_val[0];
            end
            if (step_ff == half) begin
               hi_in    = cell_val[0];
               state_in = ST_FINISH;
            end
            step_in = step_ff + count_type'(1);
         end
         ST_FINISH: begin
            // Hold until the output register is free, then publish and clear the set.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = median_type'(lo_ff) + median_type'(hi_ff);
               rsp_count_in  = item_count_type'(count_ff);
               rsp_ovf_in    = overflow_ff;
               count_in      = '0;
               overflow_in   = 1'b0;
               state_in      = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.median_twice = rsp_median_ff;
   assign rsp_if.item_count   = rsp_count_ff;
   assign rsp_if.overflowed   = rsp_ovf_ff;

endmodule
